// ----- hdl/rvm_pkg.sv -----
`default_nettype none
package rvm_pkg;

  // Field and configuration widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_W      = 13;
  localparam int STR_W      = 8;
  localparam int COL_W      = 11;
  localparam int LEVEL_W    = 8;

  // Derived arithmetic widths (dimensions never exceed 13 bits)
  localparam int CX_W     = DIM_W - 1;      // half dimension
  localparam int SQ_W     = 2 * CX_W;       // square of a half dimension
  localparam int DIST_W   = SQ_W + 1;       // dx^2 + dy^2
  localparam int RATIO_W  = 14;             // max 255*256/6 = 10880
  localparam int NUM_W    = DIST_W + RATIO_W;
  localparam int RADIUS_W = SQ_W + 1;       // (three squares) / 2
  localparam int QUO_W    = LEVEL_W;
  localparam int REM_W    = RADIUS_W + QUO_W;

  // Divide by 3 through a reciprocal: floor(x/3) = (x * 43691) >> 17 for x < 2^15
  localparam int DIV3_IN_W  = STR_W + 7;
  localparam int DIV3_MUL   = 43691;
  localparam int DIV3_SHIFT = 17;
  localparam int DIV3_PROD_W = DIV3_IN_W + DIV3_SHIFT - 1;

  // Cycles for the derived registers to follow a configuration change
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOLID_MODE   = 2'd3;

  // Reset values
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [STR_W-1:0] RST_STRENGTH     = 8'd1;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;

  // Geometry shared by the pixel pipeline, stable while pixels flow
  typedef struct packed {
    logic [CX_W-1:0]     cx;
    logic [CX_W-1:0]     cy;
    logic [RADIUS_W-1:0] radius;
    logic [RATIO_W-1:0]  ratio;
    logic                zero_radius;
  } geom_t;

endpackage
`default_nettype wire

// ----- hdl/rvm_if.sv -----
`default_nettype none

// Configuration write channel
interface rvm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rvm_pkg::CFG_IDX_W-1:0]  index;
  logic [rvm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// Pixel position channel
interface rvm_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rvm_pkg::COL_W-1:0] column;
  logic [rvm_pkg::COL_W-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

// Mask level channel
interface rvm_level_if;
  logic                        valid;
  logic                        ready;
  logic [rvm_pkg::LEVEL_W-1:0] mask_level;
  modport source (output valid, mask_level, input ready);
  modport sink   (input valid, mask_level, output ready);
endinterface

`default_nettype wire

// ----- hdl/rvm_setup.sv -----
`default_nettype none
module rvm_setup #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst,
  rvm_cfg_if.sink        cfg,
  output rvm_pkg::geom_t geom,
  output logic           settled
);

  localparam int DW = rvm_pkg::DIM_W;
  localparam int CW = rvm_pkg::CX_W;
  localparam int SW = rvm_pkg::SQ_W;
  localparam int DIM_ALL = (1 << DW) - 1;
  localparam logic [DW-1:0] SAT_DIM = DW'((MAX_DIM > DIM_ALL) ? DIM_ALL : MAX_DIM);

  logic [DW-1:0]               image_width;
  logic [DW-1:0]               image_height;
  logic [rvm_pkg::STR_W-1:0]   strength;
  logic                        solid_mode;
  logic [1:0]                  settle;

  logic [DW-1:0]               w_sat, h_sat;
  logic [CW-1:0]               cx_next, cy_next, side_next;
  logic [rvm_pkg::DIV3_IN_W-1:0]   scaled;
  logic [rvm_pkg::DIV3_PROD_W-1:0] div3_prod;

  // First derived stage
  logic [CW-1:0]                  cx_a, cy_a;
  logic [SW-1:0]                  sq_x, sq_y, sq_s;
  logic [rvm_pkg::RATIO_W-1:0]    ratio_a;
  logic [SW+1:0]                  sq_sum;

  assign cfg.ready = 1'b1;
  assign settled   = (settle == 2'd0);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rvm_pkg::RST_IMAGE_WIDTH;
      image_height <= rvm_pkg::RST_IMAGE_HEIGHT;
      strength     <= rvm_pkg::RST_STRENGTH;
      solid_mode   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rvm_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        rvm_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        rvm_pkg::REG_STRENGTH:     strength     <= cfg.data[rvm_pkg::STR_W-1:0];
        rvm_pkg::REG_SOLID_MODE:   solid_mode   <= cfg.data[0];
      endcase
    end
  end

  // Hold off pixels until the derived registers follow the registers
  always_ff @(posedge clk) begin
    if (rst || cfg.valid) begin
      settle <= rvm_pkg::SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // Saturate, halve, pick the longer side, scale the strength for the ratio
  always_comb begin
    w_sat     = (image_width  > SAT_DIM) ? SAT_DIM : image_width;
    h_sat     = (image_height > SAT_DIM) ? SAT_DIM : image_height;
    cx_next   = w_sat[DW-1:1];
    cy_next   = h_sat[DW-1:1];
    side_next = (w_sat >= h_sat) ? cx_next : cy_next;
    scaled    = {strength, 7'd0};
    div3_prod = rvm_pkg::DIV3_PROD_W'(scaled) *
                rvm_pkg::DIV3_PROD_W'(rvm_pkg::DIV3_MUL);
  end

  // Squares and ratio
  always_ff @(posedge clk) begin
    cx_a    <= cx_next;
    cy_a    <= cy_next;
    sq_x    <= SW'(cx_next) * SW'(cx_next);
    sq_y    <= SW'(cy_next) * SW'(cy_next);
    sq_s    <= SW'(side_next) * SW'(side_next);
    ratio_a <= solid_mode ? '0 :
               div3_prod[rvm_pkg::DIV3_PROD_W-1 -: rvm_pkg::RATIO_W];
  end

  assign sq_sum = (SW+2)'(sq_x) + (SW+2)'(sq_y) + (SW+2)'(sq_s);

  // Radius and zero check
  always_ff @(posedge clk) begin
    geom.cx          <= cx_a;
    geom.cy          <= cy_a;
    geom.radius      <= sq_sum[SW+1:1];
    geom.ratio       <= ratio_a;
    geom.zero_radius <= (sq_sum[SW+1:1] == '0);
  end

endmodule
`default_nettype wire

// ----- hdl/rvm_dist.sv -----
`default_nettype none
module rvm_dist (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [rvm_pkg::COL_W-1:0] column,
  input  wire logic [rvm_pkg::COL_W-1:0] row,
  input  wire rvm_pkg::geom_t            geom,
  output logic                           out_valid,
  output logic [rvm_pkg::NUM_W-1:0]      num
);

  localparam int CW = rvm_pkg::CX_W;
  localparam int SW = rvm_pkg::SQ_W;
  localparam int DSW = rvm_pkg::DIST_W;
  localparam int NW = rvm_pkg::NUM_W;

  logic [3:0]      v;
  logic [CW-1:0]   col_x, row_y;
  logic [CW-1:0]   dx, dy;
  logic [SW-1:0]   dx2, dy2;
  logic [DSW-1:0]  dist_sq;

  assign col_x = CW'(column);
  assign row_y = CW'(row);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  // Absolute offsets, squares, sum, scale by ratio
  always_ff @(posedge clk) begin
    if (en) begin
      dx      <= (geom.cx >= col_x) ? geom.cx - col_x : col_x - geom.cx;
      dy      <= (geom.cy >= row_y) ? geom.cy - row_y : row_y - geom.cy;
      dx2     <= SW'(dx) * SW'(dx);
      dy2     <= SW'(dy) * SW'(dy);
      dist_sq <= DSW'(dx2) + DSW'(dy2);
      num     <= NW'(dist_sq) * NW'(geom.ratio);
    end
  end

  assign out_valid = v[3];

endmodule
`default_nettype wire

// ----- hdl/rvm_div.sv -----
`default_nettype none
module rvm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [rvm_pkg::NUM_W-1:0]   num,
  input  wire rvm_pkg::geom_t              geom,
  output logic                             out_valid,
  output logic [rvm_pkg::LEVEL_W-1:0]      level
);

  localparam int QW = rvm_pkg::QUO_W;
  localparam int RW = rvm_pkg::REM_W;
  localparam int NW = rvm_pkg::NUM_W;

  logic [NW-1:0] full_lim;
  logic          v    [0:QW];
  logic          big  [0:QW];
  logic [RW-1:0] rem  [0:QW];
  logic [QW-1:0] quo  [0:QW];

  assign full_lim = NW'(geom.radius) << QW;

  // Quotient of 2^QW or more clips to black
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big[0] <= (num >= full_lim);
      rem[0] <= num[RW-1:0];
      quo[0] <= '0;
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int K = QW - j;
    logic [RW-1:0] trial;
    logic          fits;

    assign trial = RW'(geom.radius) << K;
    assign fits  = (rem[j-1] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        big[j] <= big[j-1];
        rem[j] <= fits ? rem[j-1] - trial : rem[j-1];
        quo[j] <= quo[j-1] | (QW'(fits) << K);
      end
    end
  end

  // Output register: 256 - q with clipping
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (geom.zero_radius) begin
        level <= rvm_pkg::LEVEL_MAX;
      end else if (big[QW]) begin
        level <= rvm_pkg::LEVEL_MIN;
      end else if (quo[QW] == '0) begin
        level <= rvm_pkg::LEVEL_MAX;
      end else begin
        level <= QW'((QW+1)'(1 << QW) - (QW+1)'(quo[QW]));
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/radial_vignette_mask_pixel.sv -----
// Radial vignette mask, one gray level per pixel position.
//
// cfg:   register writes (index 0 image_width, 1 image_height,
//        2 darkening_strength, 3 solid_mode). Always ready; write only
//        while no pixel transaction is in flight.
// pixel: one (column, row) transaction per mask pixel.
// mask:  one mask_level transaction per pixel, in input order.
//
// Throughput is one pixel per cycle unless a blocked result or a settling period
// holds pixel.ready low. A pixel transaction reaches mask.valid through registers
// that form the offsets, squares, distance and the product with the ratio, then
// a range check against the radius and a divider that resolves one quotient bit
// per stage, then the output register. After reset and after each configuration
// write, pixel.ready stays low while the center, radius and ratio registers update.
// When mask.ready is low with a result waiting, the whole pipeline holds and
// pixel.ready drops in the same cycle; nothing is dropped or repeated.
`default_nettype none
module radial_vignette_mask_pixel #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rvm_cfg_if.sink     cfg,
  rvm_pix_if.sink     pixel,
  rvm_level_if.source mask
);

  rvm_pkg::geom_t              geom;
  logic                        settled;
  logic                        en;
  logic                        pix_take;
  logic                        num_valid;
  logic [rvm_pkg::NUM_W-1:0]   num;

  // Pipeline advances unless a finished result is blocked
  assign en          = !mask.valid || mask.ready;
  assign pixel.ready = en && settled;
  assign pix_take    = pixel.valid && pixel.ready;

  rvm_setup #(
    .MAX_DIM (MAX_DIM)
  ) u_setup (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .geom    (geom),
    .settled (settled)
  );

  rvm_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pix_take),
    .column    (pixel.column),
    .row       (pixel.row),
    .geom      (geom),
    .out_valid (num_valid),
    .num       (num)
  );

  rvm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (num_valid),
    .num       (num),
    .geom      (geom),
    .out_valid (mask.valid),
    .level     (mask.mask_level)
  );

endmodule
`default_nettype wire
